>>> rtl/ffa_pkg.sv
package ffa_pkg;

    // Fixed field widths of the request and response channels.
    localparam int OP_W    = 2;
    localparam int SIZE_W  = 16;
    localparam int OFS_W   = 16;
    localparam int ST_W    = 2;
    localparam int LIMIT_W = 17;

    // A request plus its header, rounded up to the alignment, fits in this width.
    localparam int NEED_W = 17;

    // Every block carries a header of this many bytes in front of its payload.
    localparam int HDR_BYTES = 16;

    // The break may not reach this value, or the payload offset overflows 16 bits.
    localparam int PAY_LIMIT = 65536 - HDR_BYTES;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    // Defaults for the top level parameters.
    localparam int FREE_SLOTS_DEF  = 64;
    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int ALIGN_BYTES_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RESIZE  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOH  = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } status_t;

endpackage

>>> rtl/ffa_if.sv
interface ffa_req_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    op_t               operation;
    logic [SIZE_W-1:0] request_size;
    logic [OFS_W-1:0]  block_offset;

    modport source (output valid, output operation, output request_size,
                    output block_offset, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_offset, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OFS_W-1:0]  result_offset;
    logic [SIZE_W-1:0] copy_length;
    status_t           status;

    modport source (output valid, output result_offset, output copy_length,
                    output status, input ready);
    modport sink   (input valid, input result_offset, input copy_length,
                    input status, output ready);
endinterface

>>> rtl/ffa_ram.sv
module ffa_ram
    import ffa_pkg::*;
#(
    parameter int DEPTH = FREE_SLOTS_DEF,
    parameter int WIDTH = SIZE_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    // Simple dual-port memory with a registered read port.
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/first_fit_free_list_allocator.sv
// Init finishes at once; release reads the block's header and adds an entry if there is room;
// allocate scans the free entries newest first, shifting newer ones down on a hit, or else
// grows the break; resize allocates and then releases the named old block like a release.
// One request at a time, the next taken in the cycle after the response registers; a response
// stalled on the output holds the finish step. Each entry examined passes SCAN and CHECK.
// Reset (rst_n, asynchronous, active low) empties the table, zeroes the break, limit 65536.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    ffa_req_if.sink            req,
    ffa_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    // Derived sizes. The slot index addresses the free table; the count has one
    // more bit so that it can hold FREE_SLOTS itself.
    localparam int SLOT_W   = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(FREE_SLOTS + 1);
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int BLK_CNT  = HEAP_BYTES / ALIGN_BYTES;
    localparam int BLK_W    = $clog2(BLK_CNT);
    localparam int BRK_W    = $clog2(HEAP_BYTES + 1);
    localparam int CMP_W    = ((BRK_W > LIMIT_W) ? BRK_W : LIMIT_W) + 1;
    localparam int ENT_W    = BLK_W + SIZE_W;

    // Sequencer states. SCAN and CHECK walk the table newest first, SHIFT and
    // SHIFT_WR close the gap left by a taken entry, PREP and GROW extend the
    // break, HREAD and HWAIT fetch the old block's header for release or resize.
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN     = 10'b00_0000_0010,
        S_CHECK    = 10'b00_0000_0100,
        S_SHIFT    = 10'b00_0000_1000,
        S_SHIFT_WR = 10'b00_0001_0000,
        S_PREP     = 10'b00_0010_0000,
        S_GROW     = 10'b00_0100_0000,
        S_HREAD    = 10'b00_1000_0000,
        S_HWAIT    = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [BLK_W-1:0]   idx_reg, idx_next;
    logic               offv_reg, offv_next;
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BRK_W-1:0]   brk_reg, brk_next;
    logic [CMP_W-1:0]   room_reg, room_next;
    logic               pfail_reg, pfail_next;
    logic [OFS_W-1:0]   res_reg, res_next;
    logic [SIZE_W-1:0]  copy_reg, copy_next;
    status_t            st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    logic [OFS_W-1:0]   out_res_reg, out_res_next;
    logic [SIZE_W-1:0]  out_copy_reg, out_copy_next;
    status_t            out_st_reg, out_st_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    // Free table memory: each entry is {block index, recorded size}.
    logic              ft_we;
    logic [SLOT_W-1:0] ft_waddr;
    logic [ENT_W-1:0]  ft_wdata;
    logic [SLOT_W-1:0] ft_raddr;
    logic [ENT_W-1:0]  ft_rdata;

    // Header store: the requested size of every block, by block index.
    logic              hd_we;
    logic [BLK_W-1:0]  hd_waddr;
    logic [SIZE_W-1:0] hd_wdata;
    logic [SIZE_W-1:0] hd_rdata;

    // The comparator that the check, header wait, prep and grow steps share.
    logic [CMP_W-1:0]  cmp_a, cmp_b;
    logic              cmp_ge;

    logic [OFS_W-1:0]  ofs_start;
    logic              ofs_ok;
    logic [BLK_W-1:0]  ofs_idx;
    logic [NEED_W-1:0] need_calc;
    logic [BLK_W-1:0]  ent_start;
    logic [SIZE_W-1:0] ent_bytes;
    logic [CNT_W-1:0]  ptr_dec;
    logic [CNT_W:0]    ptr_inc;
    logic [CMP_W-1:0]  lim;
    logic [BLK_W+ALIGN_SH-1:0] ent_addr;

    ffa_ram #(
        .DEPTH (FREE_SLOTS),
        .WIDTH (ENT_W),
        .AW    (SLOT_W)
    ) u_free_tab (
        .clk   (clk),
        .we    (ft_we),
        .waddr (ft_waddr),
        .wdata (ft_wdata),
        .raddr (ft_raddr),
        .rdata (ft_rdata)
    );

    ffa_ram #(
        .DEPTH (BLK_CNT),
        .WIDTH (SIZE_W),
        .AW    (BLK_W)
    ) u_hdr_store (
        .clk   (clk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (idx_reg),
        .rdata (hd_rdata)
    );

    // Decode of an incoming payload offset. An offset below the header size, or
    // one whose block start lies past the heap, names no block. A misaligned
    // start is rounded down to the alignment.
    assign ofs_start = req.block_offset - OFS_W'(HDR_BYTES);
    assign ofs_ok    = (req.block_offset >= OFS_W'(HDR_BYTES)) &&
                       (32'(ofs_start) < 32'(HEAP_BYTES));
    assign ofs_idx   = BLK_W'(ofs_start >> ALIGN_SH);

    // Growth of the break: request plus header, rounded up to the alignment.
    assign need_calc = (NEED_W'(req.request_size) + NEED_W'(HDR_BYTES + ALIGN_BYTES - 1)) &
                       ~NEED_W'(ALIGN_BYTES - 1);

    assign ent_start = ft_rdata[ENT_W-1:SIZE_W];
    assign ent_bytes = ft_rdata[SIZE_W-1:0];
    assign ent_addr  = {ent_start, {ALIGN_SH{1'b0}}};
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign ptr_inc   = {1'b0, ptr_reg} + (CNT_W+1)'(1);

    // A limit above the heap size acts as the heap size.
    assign lim = (CMP_W'(limit_reg) < CMP_W'(HEAP_BYTES)) ? CMP_W'(limit_reg)
                                                         : CMP_W'(HEAP_BYTES);

    always_comb
    begin
        case (state_reg)
            S_CHECK:
            begin
                cmp_a = CMP_W'(ent_bytes);
                cmp_b = CMP_W'(size_reg);
            end
            S_HWAIT:
            begin
                cmp_a = CMP_W'(hd_rdata);
                cmp_b = CMP_W'(size_reg);
            end
            S_PREP:
            begin
                cmp_a = lim;
                cmp_b = CMP_W'(brk_reg);
            end
            S_GROW:
            begin
                cmp_a = room_reg;
                cmp_b = CMP_W'(need_reg);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_ge = cmp_a >= cmp_b;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.result_offset = out_res_reg;
    assign rsp.copy_length   = out_copy_reg;
    assign rsp.status        = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        offv_next      = offv_reg;
        need_next      = need_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        brk_next       = brk_reg;
        room_next      = room_reg;
        pfail_next     = pfail_reg;
        res_next       = res_reg;
        copy_next      = copy_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_res_next   = out_res_reg;
        out_copy_next  = out_copy_reg;
        out_st_next    = out_st_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;

        ft_we    = 1'b0;
        ft_waddr = ptr_reg[SLOT_W-1:0];
        ft_wdata = ft_rdata;
        ft_raddr = ptr_dec[SLOT_W-1:0];
        hd_we    = 1'b0;
        hd_waddr = BLK_W'(brk_reg >> ALIGN_SH);
        hd_wdata = size_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.operation;
                    size_next = req.request_size;
                    idx_next  = ofs_idx;
                    offv_next = ofs_ok;
                    need_next = need_calc;
                    ptr_next  = cnt_reg;
                    res_next  = '0;
                    copy_next = '0;
                    st_next   = ST_OK;
                    case (req.operation)
                        OP_INIT:
                        begin
                            cnt_next   = '0;
                            state_next = S_DONE;
                        end
                        OP_RELEASE:
                        begin
                            if (ofs_ok)
                            begin
                                state_next = S_HREAD;
                            end
                            else
                            begin
                                st_next    = ST_NULL;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The read of entry ptr-1 is issued here; nothing left means growth.
                if (ptr_reg == '0)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                ptr_next = ptr_dec;
                if (cmp_ge)
                begin
                    res_next   = OFS_W'(ent_addr) + OFS_W'(HDR_BYTES);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SHIFT:
            begin
                ft_raddr = ptr_inc[SLOT_W-1:0];
                if (ptr_inc < {1'b0, cnt_reg})
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = (op_reg == OP_RESIZE && offv_reg) ? S_HREAD : S_DONE;
                end
            end

            S_SHIFT_WR:
            begin
                ft_we      = 1'b1;
                ptr_next   = ptr_inc[CNT_W-1:0];
                state_next = S_SHIFT;
            end

            S_PREP:
            begin
                room_next  = lim - CMP_W'(brk_reg);
                pfail_next = !cmp_ge || (CMP_W'(brk_reg) >= CMP_W'(PAY_LIMIT));
                state_next = S_GROW;
            end

            S_GROW:
            begin
                if (cmp_ge && !pfail_reg)
                begin
                    hd_we      = 1'b1;
                    brk_next   = brk_reg + BRK_W'(need_reg);
                    res_next   = OFS_W'(brk_reg) + OFS_W'(HDR_BYTES);
                    state_next = (op_reg == OP_RESIZE && offv_reg) ? S_HREAD : S_DONE;
                end
                else
                begin
                    // A failed resize leaves the old block where it is.
                    res_next   = '0;
                    st_next    = ST_OOH;
                    state_next = S_DONE;
                end
            end

            S_HREAD:
            begin
                state_next = S_HWAIT;
            end

            S_HWAIT:
            begin
                if (op_reg == OP_RESIZE)
                begin
                    copy_next = cmp_ge ? size_reg : hd_rdata;
                end
                if (cnt_reg >= CNT_W'(FREE_SLOTS))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    ft_we    = 1'b1;
                    ft_waddr = cnt_reg[SLOT_W-1:0];
                    ft_wdata = {idx_reg, hd_rdata};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_copy_next  = copy_reg;
                    out_st_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            brk_reg       <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            brk_reg       <= brk_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        idx_reg      <= idx_next;
        offv_reg     <= offv_next;
        need_reg     <= need_next;
        ptr_reg      <= ptr_next;
        room_reg     <= room_next;
        pfail_reg    <= pfail_next;
        res_reg      <= res_next;
        copy_reg     <= copy_next;
        st_reg       <= st_next;
        out_res_reg  <= out_res_next;
        out_copy_reg <= out_copy_next;
        out_st_reg   <= out_st_next;
    end

`ifndef SYNTHESIS
    // The free table never holds more entries than it has slots.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FREE_SLOTS))
        else $error("free table count exceeds its slots");

    // The break only ever grows.
    a_brk_grows: assert property (@(posedge clk) disable iff (!rst_n)
        brk_reg >= $past(brk_reg))
        else $error("heap break moved backward");

    // A response appears only when the sequencer finishes a request.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the finish step");

    // An out-of-heap response grants nothing and asks for no copy.
    a_ooh_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_OOH) |-> (rsp.result_offset == '0 &&
                                                  rsp.copy_length == '0))
        else $error("out-of-heap response carries a block");
`endif

endmodule

>>> test/tb_first_fit_free_list_allocator.sv
`timescale 1ns / 1ps

// Self-checking testbench for the first-fit free list allocator.
//
// A generator in the main initial block fills a queue of pending requests. A clocked
// driver presents them on the request channel, and for every request the block accepts
// it runs the allocator predictor, which keeps its own copy of the free table, the
// break, the header store and the heap limit. The predicted response goes onto a queue
// of expected grants. A clocked monitor on the response channel compares every
// accepted response with the oldest expected grant, field by field.
module tb_first_fit_free_list_allocator
    import ffa_pkg::*;
();

    localparam int ALIGN      = ALIGN_BYTES_DEF;
    localparam int SLOTS      = FREE_SLOTS_DEF;
    localparam int HEAP_SIZE  = HEAP_BYTES_DEF;
    localparam int BLOCKS     = HEAP_SIZE / ALIGN;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        op_t               op;
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  ofs;
    } alloc_req_t;

    typedef struct packed {
        logic [OFS_W-1:0]  ofs;
        logic [SIZE_W-1:0] copy;
        status_t           st;
    } grant_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_free_list_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Channel traffic and bookkeeping.
    alloc_req_t        pending_requests[$];
    grant_t            expected_grants[$];
    logic [OFS_W-1:0]  granted_offsets[$];
    int                send_idle_pct;
    int                stall_pct;
    int                mismatches;
    int                op_seen[4];
    int                status_seen[4];

    // Predictor state: the free table, the break, the header store and the limit.
    logic [11:0]        free_start[SLOTS];
    logic [16:0]        free_bytes[SLOTS];
    int                 free_count;
    int                 heap_break;
    logic [16:0]        header_size[BLOCKS];
    bit                 header_written[BLOCKS];
    logic [LIMIT_W-1:0] heap_limit_model;

    always #6 clk = ~clk;

    // The run is bounded well above the slowest legal run; a hang ends here.
    initial
    begin
        #15_000_000;
        $display("FAIL first_fit_free_list_allocator");
        $finish;
    end

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Map a payload offset to its block index. Offsets below the header size name no
    // block; a misaligned offset simply rounds down to the block that holds it.
    function automatic bit decode_block(input logic [OFS_W-1:0] ofs, output int idx);
        int start;
        idx = 0;
        if (ofs < HDR_BYTES)
            return 0;
        start = int'(ofs) - HDR_BYTES;
        if (start >= HEAP_SIZE)
            return 0;
        idx = start / ALIGN;
        return idx < BLOCKS;
    endfunction

    // First fit from the newest free entry, otherwise grow the break.
    function automatic status_t alloc_block(input logic [SIZE_W-1:0] size,
                                            output logic [OFS_W-1:0] grant);
        int k;
        int need;
        int lim;
        int pay;
        grant = '0;
        for (int i = free_count; i > 0; i--)
        begin
            k = i - 1;
            if (free_bytes[k] >= {1'b0, size})
            begin
                grant = OFS_W'(int'(free_start[k]) * ALIGN + HDR_BYTES);
                // The entry leaves whole; newer entries slide down one slot.
                while (k + 1 < free_count)
                begin
                    free_start[k] = free_start[k + 1];
                    free_bytes[k] = free_bytes[k + 1];
                    k++;
                end
                free_count--;
                return ST_OK;
            end
        end
        need = ((int'(size) + HDR_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
        lim  = (int'(heap_limit_model) < HEAP_SIZE) ? int'(heap_limit_model) : HEAP_SIZE;
        if (heap_break > lim || need > lim - heap_break)
            return ST_OOH;
        pay = heap_break + HDR_BYTES;
        if (pay > 65535)
            return ST_OOH;
        header_size[heap_break / ALIGN]    = {1'b0, size};
        header_written[heap_break / ALIGN] = 1'b1;
        heap_break += need;
        grant = OFS_W'(pay);
        return ST_OK;
    endfunction

    function automatic status_t release_block(input int idx);
        if (free_count >= SLOTS)
            return ST_FULL;
        free_start[free_count] = 12'(idx);
        free_bytes[free_count] = header_size[idx];
        free_count++;
        return ST_OK;
    endfunction

    // Predict the response to one accepted request and queue it.
    function automatic void model_request(input alloc_req_t r);
        grant_t          g;
        int              idx;
        bit              named;
        status_t         s;
        logic [16:0]     hdr;
        g.ofs  = '0;
        g.copy = '0;
        g.st   = ST_OK;
        op_seen[r.op]++;
        case (r.op)
            OP_INIT:
                free_count = 0;
            OP_ALLOC:
                g.st = alloc_block(r.size, g.ofs);
            OP_RELEASE:
                if (decode_block(r.ofs, idx))
                    g.st = release_block(idx);
                else
                    g.st = ST_NULL;
            default:
            begin
                // Resize: allocate first, then hand back the old block. A null old
                // block turns the resize into a plain allocate with nothing to copy.
                named = decode_block(r.ofs, idx);
                s = alloc_block(r.size, g.ofs);
                if (s != ST_OK)
                begin
                    g.ofs = '0;
                    g.st  = s;
                end
                else if (named)
                begin
                    hdr    = header_size[idx];
                    g.copy = ({1'b0, r.size} < hdr) ? r.size : hdr[SIZE_W-1:0];
                    g.st   = release_block(idx);
                end
            end
        endcase
        if ((r.op == OP_ALLOC || r.op == OP_RESIZE) && g.st != ST_OOH)
            granted_offsets.push_back(g.ofs);
        expected_grants.push_back(g);
    endfunction

    // Driver: a request is accepted at an edge where valid and ready are both high.
    // A presented request is held until it is taken; otherwise the next one goes out
    // unless the sender decides to idle this cycle.
    always @(posedge clk)
    begin : request_driver
        alloc_req_t head;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                head = pending_requests.pop_front();
                model_request(head);
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // Keep the current request on the channel.
            end
            else if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                head = pending_requests[0];
                req_ch.valid        <= 1'b1;
                req_ch.operation    <= head.op;
                req_ch.request_size <= head.size;
                req_ch.block_offset <= head.ofs;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted response with the oldest expected grant.
    always @(posedge clk)
    begin : response_monitor
        grant_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                status_seen[rsp_ch.status]++;
                if (expected_grants.size() == 0)
                begin
                    note_failure($sformatf("response %0d/%0d/%0d with nothing expected",
                                           rsp_ch.result_offset, rsp_ch.copy_length,
                                           rsp_ch.status));
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp_ch.result_offset !== want.ofs)
                        note_failure($sformatf("result_offset expected %0d got %0d",
                                               want.ofs, rsp_ch.result_offset));
                    if (rsp_ch.copy_length !== want.copy)
                        note_failure($sformatf("copy_length expected %0d got %0d",
                                               want.copy, rsp_ch.copy_length));
                    if (rsp_ch.status !== want.st)
                        note_failure($sformatf("status expected %s got %0d",
                                               want.st.name(), rsp_ch.status));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // The generator stays only a few requests ahead of the driver, so the pool of
    // granted offsets it draws from is nearly current. Any header that is written by
    // the time a request is generated is still written when that request is accepted.
    task automatic push_request(input op_t op, input int size, input int ofs);
        alloc_req_t r;
        while (pending_requests.size() >= 4)
            @(negedge clk);
        r.op   = op;
        r.size = SIZE_W'(size);
        r.ofs  = OFS_W'(ofs);
        pending_requests.push_back(r);
    endtask

    // Wait until every request has been taken and every response has come back.
    task automatic wait_for_idle();
        while (pending_requests.size() != 0 || expected_grants.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The heap limit is written only while the block is idle, so the predictor copy
    // can follow at once.
    task automatic write_heap_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        heap_limit_model = value;
    endtask

    // Mostly modest sizes so the heap lasts, with a tail of large ones.
    function automatic int pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return $urandom_range(127);
        else if (p < 92)
            return $urandom_range(1023);
        else if (p < 97)
            return $urandom_range(8191);
        return $urandom_range(65535);
    endfunction

    // An offset that was handed out earlier, sometimes with the low bits disturbed.
    function automatic int pick_block_offset();
        int ofs;
        if (granted_offsets.size() == 0)
            return $urandom_range(15);
        ofs = granted_offsets[$urandom_range(granted_offsets.size() - 1)];
        if ($urandom_range(3) == 0)
            ofs = ofs | $urandom_range(15);
        return ofs;
    endfunction

    // Null offsets, or an arbitrary offset when it lands in a block that exists.
    function automatic int pick_stray_offset();
        int ofs;
        ofs = $urandom_range(65535);
        if ($urandom_range(1) == 0 || ofs < HDR_BYTES)
            return $urandom_range(15);
        if (!header_written[(ofs - HDR_BYTES) / ALIGN])
            return $urandom_range(15);
        return ofs;
    endfunction

    task automatic run_random(input int count, input int send_pct, input int stall);
        int p;
        send_idle_pct = send_pct;
        stall_pct     = stall;
        repeat (count)
        begin
            p = $urandom_range(99);
            if (p < 30)
                push_request(OP_ALLOC, pick_size(), 0);
            else if (p < 52)
                push_request(OP_RELEASE, $urandom_range(65535), pick_block_offset());
            else if (p < 70)
                push_request(OP_RESIZE, pick_size(), pick_block_offset());
            else if (p < 78)
                push_request(OP_RELEASE, $urandom_range(65535), pick_stray_offset());
            else if (p < 85)
                push_request(OP_RESIZE, pick_size(), pick_stray_offset());
            else if (p < 90)
                push_request(OP_INIT, $urandom_range(65535), $urandom_range(65535));
            else
                push_request(OP_ALLOC, $urandom_range(31), 0);
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = LIMIT_RESET;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_INIT;
        req_ch.request_size = '0;
        req_ch.block_offset = '0;
        rsp_ch.ready        = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        mismatches       = 0;
        free_count       = 0;
        heap_break       = 0;
        heap_limit_model = LIMIT_RESET;
        for (int i = 0; i < 4; i++)
        begin
            op_seen[i]     = 0;
            status_seen[i] = 0;
        end
        for (int i = 0; i < BLOCKS; i++)
        begin
            header_size[i]    = '0;
            header_written[i] = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_heap_limit(LIMIT_RESET);

        // Directed opening, no idling. The first large block brings the break just under
        // 32 KiB so that the next offset uses the top bit.
        push_request(OP_INIT, 0, 0);
        push_request(OP_ALLOC, 0, 0);            // smallest block at offset 16
        push_request(OP_ALLOC, 65535, 0);        // largest request cannot fit
        push_request(OP_ALLOC, 32720, 0);        // one block of just under 32 KiB
        push_request(OP_ALLOC, 1, 0);            // first offset with bit 15 set
        push_request(OP_RELEASE, 0, 0);          // null is ignored
        push_request(OP_RELEASE, 0, 15);         // offset inside the header area
        push_request(OP_RELEASE, 65535, 16);
        push_request(OP_RELEASE, 0, 32783);      // misaligned, rounds down
        push_request(OP_ALLOC, 1, 0);            // reuse gives the canonical offset
        push_request(OP_ALLOC, 0, 0);
        push_request(OP_RESIZE, 10, 0);          // null resize acts as allocate
        push_request(OP_RESIZE, 100, 32);        // copy limited by the new size
        push_request(OP_RELEASE, 0, 32);         // the same block goes back twice
        push_request(OP_ALLOC, 30000, 0);
        push_request(OP_INIT, 65535, 65535);     // empties the table only
        push_request(OP_RESIZE, 65535, 32);      // fails, old block is kept
        push_request(OP_RESIZE, 0, 32775);       // nothing to copy
        push_request(OP_RESIZE, 65535, 48);
        push_request(OP_RELEASE, 0, 32768);
        push_request(OP_RESIZE, 5, 32768);
        push_request(OP_ALLOC, 65535, 0);

        // Every phase boundary holds the sender back until all responses are in.
        wait_for_idle();
        write_heap_limit(17'd48000);
        run_random(200, 0, 0);

        wait_for_idle();
        write_heap_limit(LIMIT_RESET);
        run_random(100, 56, 0);
        // Flood the free table so that releases and resizes meet a full table.
        repeat (70)
            push_request(OP_RELEASE, 0, pick_block_offset());
        push_request(OP_RESIZE, 0, pick_block_offset());
        run_random(100, 56, 0);

        // The smallest limit stops all growth; only reuse can grant a block.
        wait_for_idle();
        write_heap_limit(17'd16);
        run_random(150, 0, 56);

        // A limit just below the current break.
        wait_for_idle();
        write_heap_limit((heap_break > 64) ? LIMIT_W'(heap_break - 48) : LIMIT_W'(16));
        run_random(150, 20, 20);

        wait_for_idle();
        write_heap_limit(LIMIT_RESET);
        run_random(100, 20, 20);

        wait_for_idle();
        repeat (20) @(posedge clk);
        if (expected_grants.size() != 0)
            note_failure($sformatf("%0d responses never arrived", expected_grants.size()));

        $display("Ran %0d init, %0d allocate, %0d release and %0d resize requests; break %0d.",
                 op_seen[OP_INIT], op_seen[OP_ALLOC], op_seen[OP_RELEASE],
                 op_seen[OP_RESIZE], heap_break);
        $display("Responses: %0d ok, %0d out of heap, %0d table full, %0d null; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_OOH], status_seen[ST_FULL],
                 status_seen[ST_NULL], mismatches);
        if (mismatches == 0)
            $display("PASS first_fit_free_list_allocator");
        else
            $display("FAIL first_fit_free_list_allocator");
        $finish;
    end

endmodule
